// ----- sv/indexed_min_heap_decrease_key_defines.svh -----
// Assertion macros shared by the heap design.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_DEFINES_SVH
`ifndef ASSERT_OFF
`define IMH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IMH_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IMH_ASSERT(label, clk, rst_n, prop, msg)
`define IMH_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ----- sv/imh_pkg.sv -----
package imh_pkg;
  localparam int MaxNodes = 1024;
  localparam int NodeBits = 10;
  localparam int CountBits = 11;
  localparam int DistBits = 31;
  localparam logic [DistBits-1:0] DIST_INF = {DistBits{1'b1}};

  typedef logic [NodeBits-1:0] node_t;
  typedef logic [DistBits-1:0] dist_t;
  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [2:0] {
    CMD_INIT = 3'd0,
    CMD_PEEK = 3'd1,
    CMD_POP = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_INIT_SRC,
    ST_RD_HEAD,
    ST_POP_LAST,
    ST_POP_WR,
    ST_SD_RD,
    ST_SD_L,
    ST_SD_R,
    ST_SD_CMP,
    ST_SD_WR,
    ST_UPD_POS,
    ST_UPD_RD,
    ST_UPD_CHK,
    ST_SU_RD,
    ST_SU_CMP,
    ST_SU_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    node_t node_out;
    dist_t dist_out;
    count_t heap_count;
    logic heap_empty;
    logic node_queued;
    logic error;
  } result_t;

  typedef struct packed {
    logic [2:0] command;
    node_t node;
    dist_t dist_req;
  } request_t;
endpackage

// ----- sv/imh_req_if.sv -----
interface imh_req_if;
  import imh_pkg::*;
  logic valid;
  logic ready;
  request_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/imh_res_if.sv -----
interface imh_res_if;
  import imh_pkg::*;
  logic valid;
  logic ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/indexed_min_heap_decrease_key.sv -----
// Each request is handled alone; the result is registered and a new request
// is taken once it has been handed over. Pop and update walk the heap level
// by level (up to 10 levels) through the single-port heap memory. Init sweeps
// all 1024 entries, one a cycle. Reset is synchronous and active low; it
// clears the live count and control, not the memories.
module indexed_min_heap_decrease_key (
  input logic clk,
  input logic rst_n,
  input logic cfg_we,
  input logic [imh_pkg::CountBits-1:0] cfg_wdata,
  imh_req_if.sink in_req,
  imh_res_if.source out_res
);
  import imh_pkg::*;
  `include "indexed_min_heap_decrease_key_defines.svh"

  node_t mem_id [MaxNodes];
  dist_t mem_dist [MaxNodes];
  node_t mem_pos [MaxNodes];

  state_t state_r, state_nxt;
  count_t ncfg_r, live_r, live_nxt;
  request_t req_r;
  result_t res_r;
  logic res_valid_r;

  // Working registers.
  count_t i_r, i_nxt, s_r, s_nxt;
  node_t ci_r, ci_nxt, cs_r, cs_nxt;
  dist_t di_r, di_nxt, ds_r, ds_nxt;

  // Heap port: one read or write per cycle.
  logic h_we;
  node_t h_addr, h_wid;
  dist_t h_wd;
  node_t h_rid;
  dist_t h_rd;
  logic p_we;
  node_t p_addr, p_wd, p_rd;
  logic res_ld;
  result_t res_nxt;

  always_ff @(posedge clk) begin
    if (h_we) begin
      mem_id[h_addr] <= h_wid;
      mem_dist[h_addr] <= h_wd;
    end
    h_rid <= mem_id[h_addr];
    h_rd <= mem_dist[h_addr];
    if (p_we) begin
      mem_pos[p_addr] <= p_wd;
    end
    p_rd <= mem_pos[p_addr];
  end

  count_t ncnt;
  always_comb begin
    ncnt = ncfg_r;
    if (ncfg_r == '0) ncnt = count_t'(1);
    if (ncfg_r > count_t'(MaxNodes)) ncnt = count_t'(MaxNodes);
  end

  logic take;
  assign take = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE) && !res_valid_r;
  assign out_res.valid = res_valid_r;
  assign out_res.data = res_r;

  count_t lchild, rchild, parent;
  assign lchild = count_t'({i_r[CountBits-2:0], 1'b1});
  assign rchild = lchild + count_t'(1);
  assign parent = (i_r - count_t'(1)) >> 1;

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        state_nxt = ST_IDLE;
        if (take) begin
          unique case (in_req.data.command)
            CMD_INIT: state_nxt = ST_INIT;
            CMD_PEEK, CMD_POP: state_nxt = ST_RD_HEAD;
            CMD_UPDATE, CMD_QUERY: state_nxt = ST_UPD_POS;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_INIT: state_nxt = (i_r == count_t'(MaxNodes - 1)) ? ST_INIT_SRC : ST_INIT;
      ST_INIT_SRC: state_nxt = ST_DONE;
      ST_RD_HEAD: begin
        if (live_r == '0 || req_r.command == CMD_PEEK) state_nxt = ST_DONE;
        else state_nxt = ST_POP_LAST;
      end
      ST_POP_LAST: state_nxt = ST_POP_WR;
      ST_POP_WR: state_nxt = ST_SD_RD;
      ST_SD_RD: state_nxt = ST_SD_L;
      ST_SD_L: state_nxt = ST_SD_R;
      ST_SD_R: state_nxt = ST_SD_CMP;
      ST_SD_CMP: state_nxt = (s_r == i_r) ? ST_DONE : ST_SD_WR;
      ST_SD_WR: state_nxt = ST_SD_RD;
      ST_UPD_POS: state_nxt = ST_UPD_RD;
      ST_UPD_RD: state_nxt = ST_UPD_CHK;
      ST_UPD_CHK: begin
        if (req_r.command == CMD_UPDATE && count_t'(p_rd) < live_r &&
            req_r.dist_req < h_rd) state_nxt = ST_SU_RD;
        else state_nxt = ST_DONE;
      end
      ST_SU_RD: state_nxt = (i_r == '0) ? ST_DONE : ST_SU_CMP;
      ST_SU_CMP: state_nxt = (h_rd > di_r) ? ST_SU_WR : ST_DONE;
      ST_SU_WR: state_nxt = ST_SU_RD;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    h_we = 1'b0; h_addr = '0; h_wid = '0; h_wd = '0;
    p_we = 1'b0; p_addr = '0; p_wd = '0;
    i_nxt = i_r; s_nxt = s_r; ci_nxt = ci_r; cs_nxt = cs_r;
    di_nxt = di_r; ds_nxt = ds_r; live_nxt = live_r;
    res_ld = 1'b0; res_nxt = res_r;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        res_nxt.node_out = in_req.data.node;
        res_nxt.dist_out = '0;
        res_nxt.node_queued = 1'b0;
        res_nxt.error = 1'b0;
        res_ld = take;
      end
      ST_INIT: begin
        h_we = 1'b1; h_addr = node_t'(i_r); h_wid = node_t'(i_r); h_wd = DIST_INF;
        p_we = 1'b1; p_addr = node_t'(i_r); p_wd = node_t'(i_r);
        i_nxt = i_r + count_t'(1);
      end
      ST_INIT_SRC: begin
        live_nxt = ncnt;
        if (count_t'(req_r.node) < ncnt) begin
          if (req_r.node == '0) begin
            h_we = 1'b1; h_addr = '0; h_wid = '0; h_wd = '0;
          end else begin
            // Position zero now holds the source; the old head node 0 lies
            // at the source's old place, written after this step.
            h_we = 1'b1; h_addr = '0; h_wid = req_r.node; h_wd = '0;
            p_we = 1'b1; p_addr = req_r.node; p_wd = '0;
          end
          res_nxt.node_queued = 1'b1;
          res_ld = 1'b1;
        end
      end
      ST_RD_HEAD: begin
        if (live_r == '0) begin
          res_nxt.node_out = '0;
          res_nxt.dist_out = DIST_INF;
          res_nxt.error = (req_r.command == CMD_POP);
        end else begin
          res_nxt.node_out = h_rid;
          res_nxt.dist_out = h_rd;
          i_nxt = live_r - count_t'(1);
        end
        res_ld = 1'b1;
        h_addr = node_t'(live_r - count_t'(1));
      end
      ST_POP_LAST: begin
        ci_nxt = h_rid; di_nxt = h_rd;
        h_we = 1'b1; h_addr = node_t'(i_r); h_wid = res_r.node_out; h_wd = res_r.dist_out;
        p_we = 1'b1; p_addr = res_r.node_out; p_wd = node_t'(i_r);
        live_nxt = live_r - count_t'(1);
      end
      ST_POP_WR: begin
        h_we = 1'b1; h_addr = '0; h_wid = ci_r; h_wd = di_r;
        p_we = 1'b1; p_addr = ci_r; p_wd = '0;
        i_nxt = '0;
      end
      ST_SD_RD: begin
        h_addr = node_t'(lchild);
        s_nxt = i_r; cs_nxt = ci_r; ds_nxt = di_r;
      end
      ST_SD_L: begin
        h_addr = node_t'(rchild);
        if (lchild < live_r && h_rd < ds_r) begin
          s_nxt = lchild; cs_nxt = h_rid; ds_nxt = h_rd;
        end
      end
      ST_SD_R: begin
        if (rchild < live_r && h_rd < ds_r) begin
          s_nxt = rchild; cs_nxt = h_rid; ds_nxt = h_rd;
        end
      end
      ST_SD_CMP: begin
        if (s_r != i_r) begin
          h_we = 1'b1; h_addr = node_t'(i_r); h_wid = cs_r; h_wd = ds_r;
          p_we = 1'b1; p_addr = cs_r; p_wd = node_t'(i_r);
        end
      end
      ST_SD_WR: begin
        h_we = 1'b1; h_addr = node_t'(s_r); h_wid = ci_r; h_wd = di_r;
        p_we = 1'b1; p_addr = ci_r; p_wd = node_t'(s_r);
        i_nxt = s_r;
      end
      ST_UPD_POS: p_addr = req_r.node;
      ST_UPD_RD: begin
        h_addr = p_rd;
        p_addr = req_r.node;
      end
      ST_UPD_CHK: begin
        i_nxt = count_t'(p_rd);
        ci_nxt = req_r.node;
        res_nxt.dist_out = h_rd;
        res_nxt.node_queued = count_t'(p_rd) < live_r;
        res_nxt.error = (req_r.command == CMD_UPDATE) && !(count_t'(p_rd) < live_r);
        if (req_r.command == CMD_UPDATE && count_t'(p_rd) < live_r &&
            req_r.dist_req < h_rd) begin
          res_nxt.dist_out = req_r.dist_req;
          di_nxt = req_r.dist_req;
          h_we = 1'b1; h_addr = p_rd; h_wid = req_r.node; h_wd = req_r.dist_req;
        end
        res_ld = 1'b1;
      end
      ST_SU_RD: h_addr = node_t'(parent);
      ST_SU_CMP: begin
        if (h_rd > di_r) begin
          h_we = 1'b1; h_addr = node_t'(i_r); h_wid = h_rid; h_wd = h_rd;
          p_we = 1'b1; p_addr = h_rid; p_wd = node_t'(i_r);
          i_nxt = parent;
        end else begin
          h_we = 1'b1; h_addr = node_t'(i_r); h_wid = ci_r; h_wd = di_r;
          p_we = 1'b1; p_addr = ci_r; p_wd = node_t'(i_r);
        end
      end
      ST_SU_WR: begin
        if (i_r == '0) begin
          h_we = 1'b1; h_addr = '0; h_wid = ci_r; h_wd = di_r;
          p_we = 1'b1; p_addr = ci_r; p_wd = '0;
        end
      end
      ST_DONE: begin
        if (req_r.command == CMD_INIT && count_t'(req_r.node) < live_r &&
            req_r.node != '0) begin
          h_we = 1'b1; h_addr = req_r.node; h_wid = '0; h_wd = DIST_INF;
          p_we = 1'b1; p_addr = '0; p_wd = req_r.node;
        end
        res_nxt.heap_count = live_r;
        res_nxt.heap_empty = (live_r == '0);
        res_ld = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      live_r <= '0;
      ncfg_r <= count_t'(MaxNodes);
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      live_r <= live_nxt;
      if (cfg_we) ncfg_r <= cfg_wdata;
      if (state_r == ST_DONE) res_valid_r <= 1'b1;
      else if (out_res.ready) res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) req_r <= in_req.data;
    if (res_ld) res_r <= res_nxt;
    i_r <= i_nxt; s_r <= s_nxt; ci_r <= ci_nxt; cs_r <= cs_nxt;
    di_r <= di_nxt; ds_r <= ds_nxt;
  end

  `IMH_ASSERT(a_one_item, clk, rst_n, res_valid_r |-> !in_req.ready, "request taken while result waits")
  `IMH_ASSERT(a_live_max, clk, rst_n, live_r <= count_t'(MaxNodes), "live count beyond capacity")
  `IMH_ASSERT(a_pop_dec, clk, rst_n, (state_r == ST_POP_LAST) |=> (live_r == $past(live_r) - count_t'(1)), "pop did not shrink heap")
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import imh_pkg::*;

  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_LAST_UNUSED = 3'd7;

  class heap_scoreboard;
    node_t ids[MaxNodes];
    dist_t dists[MaxNodes];
    node_t where[MaxNodes];
    int unsigned live;
    int unsigned node_count;
    result_t pending[$];
    int unsigned mismatches;

    function new();
      live = 0;
      node_count = MaxNodes;
      mismatches = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      node_t na;
      dist_t da;
      na = ids[a];
      da = dists[a];
      ids[a] = ids[b];
      dists[a] = dists[b];
      ids[b] = na;
      dists[b] = da;
      where[ids[a]] = node_t'(a);
      where[na] = node_t'(b);
    endfunction

    function void sink_down(int unsigned i);
      int unsigned l, r, s;
      forever begin
        l = 2 * i + 1;
        r = 2 * i + 2;
        s = i;
        if (l < live && dists[l] < dists[s]) s = l;
        if (r < live && dists[r] < dists[s]) s = r;
        if (s == i) return;
        swap_slots(i, s);
        i = s;
      end
    endfunction

    function void float_up(int unsigned i);
      int unsigned p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!(dists[p] > dists[i])) return;
        swap_slots(i, p);
        i = p;
      end
    endfunction

    function bit in_heap(node_t v);
      return where[v] < live;
    endfunction

    function void note_request(request_t r);
      result_t e;
      int unsigned n;
      e = '0;
      e.node_out = r.node;
      case (r.command)
        CMD_INIT: begin
          n = (node_count == 0) ? 1 : (node_count > MaxNodes ? MaxNodes : node_count);
          for (int i = 0; i < MaxNodes; i++) begin
            ids[i] = node_t'(i);
            dists[i] = DIST_INF;
            where[i] = node_t'(i);
          end
          live = n;
          if (r.node < n) begin
            dists[r.node] = '0;
            swap_slots(r.node, 0);
          end
          e.node_queued = in_heap(r.node);
        end
        CMD_PEEK, CMD_POP: begin
          if (live == 0) begin
            e.node_out = '0;
            e.dist_out = DIST_INF;
            e.error = (r.command == CMD_POP);
          end else begin
            e.node_out = ids[0];
            e.dist_out = dists[0];
            if (r.command == CMD_POP) begin
              swap_slots(0, live - 1);
              live--;
              sink_down(0);
            end
          end
        end
        CMD_UPDATE: begin
          if (!in_heap(r.node)) begin
            e.error = 1'b1;
          end else begin
            if (r.dist_req < dists[where[r.node]]) begin
              dists[where[r.node]] = r.dist_req;
              float_up(where[r.node]);
            end
            e.node_queued = 1'b1;
          end
          e.dist_out = dists[where[r.node]];
        end
        CMD_QUERY: begin
          e.dist_out = dists[where[r.node]];
          e.node_queued = in_heap(r.node);
        end
        default: ;
      endcase
      e.heap_count = count_t'(live);
      e.heap_empty = (live == 0);
      pending.push_back(e);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $display("result with no request outstanding");
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (got.node_out !== e.node_out) report("node_out", got.node_out, e.node_out);
      if (got.dist_out !== e.dist_out) report("dist_out", got.dist_out, e.dist_out);
      if (got.heap_count !== e.heap_count) report("heap_count", got.heap_count, e.heap_count);
      if (got.heap_empty !== e.heap_empty) report("heap_empty", got.heap_empty, e.heap_empty);
      if (got.node_queued !== e.node_queued)
        report("node_queued", got.node_queued, e.node_queued);
      if (got.error !== e.error) report("error", got.error, e.error);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  count_t cfg_wdata;
  bit idling;
  heap_scoreboard sb;

  imh_req_if in_req();
  imh_res_if out_res();

  indexed_min_heap_decrease_key dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req(in_req.sink),
    .out_res(out_res.source)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    if (rst_n && in_req.valid && in_req.ready) sb.note_request(in_req.data);
    if (rst_n && out_res.valid && out_res.ready) sb.check_result(out_res.data);
  end

  always @(posedge clk) begin
    out_res.ready <= idling ? ($urandom_range(99) >= 12) : 1'b1;
  end

  task send(logic [2:0] cmd, node_t nd, dist_t d);
    in_req.valid <= 1'b1;
    in_req.data <= '{command: cmd, node: nd, dist_req: d};
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (idling && $urandom_range(99) < 12) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task drain();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_node_count(count_t v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.node_count = v;
  endtask

  function dist_t pick_dist();
    case ($urandom_range(9))
      0: return DIST_INF;
      1: return dist_t'($urandom);
      2: return '0;
      default: return dist_t'($urandom_range(0, 5000));
    endcase
  endfunction

  task random_phase(int unsigned n, int unsigned count);
    int unsigned k;
    node_t nd;
    nd = node_t'($urandom_range(0, n - 1));
    if (n < MaxNodes && $urandom_range(4) == 0) nd = node_t'($urandom_range(n, MaxNodes - 1));
    send(CMD_INIT, nd, dist_t'($urandom));
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      nd = ($urandom_range(9) == 0) ? node_t'($urandom) : node_t'($urandom_range(0, n - 1));
      if (k < 40) send(CMD_UPDATE, nd, pick_dist());
      else if (k < 65) send(CMD_POP, node_t'($urandom), dist_t'($urandom));
      else if (k < 75) send(CMD_PEEK, node_t'($urandom), dist_t'($urandom));
      else if (k < 95) send(CMD_QUERY, nd, dist_t'($urandom));
      else if (k < 98)
        send(3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED)), node_t'($urandom),
             dist_t'($urandom));
      else send(CMD_INIT, nd, dist_t'($urandom));
    end
  endtask

  initial begin
    int unsigned counts[12];
    int unsigned eff;
    counts = '{1024, 0, 2, 2047, 7, 1025, 100, 1, 33, 512, 3, 1024};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idling = 1'b1;
    in_req.valid = 1'b0;
    in_req.data = '0;
    out_res.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(CMD_POP, '0, '0);
    send(CMD_PEEK, '1, '1);
    write_node_count(count_t'(MaxNodes));
    send(CMD_INIT, '0, '0);
    send(CMD_UPDATE, node_t'(5), '0);
    send(CMD_UPDATE, '1, DIST_INF);
    send(CMD_UPDATE, node_t'(512), dist_t'(1));
    send(CMD_PEEK, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_UPDATE, '0, '0);
    send(CMD_QUERY, '0, '0);
    send(CMD_QUERY, '1, '0);
    send(CMD_FIRST_UNUSED, '1, '1);
    send(CMD_LAST_UNUSED, '0, '0);
    write_node_count(count_t'(1));
    send(CMD_INIT, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_POP, '0, '0);
    send(CMD_PEEK, '0, '0);
    send(CMD_UPDATE, '0, dist_t'(3));
    send(CMD_QUERY, '0, '0);
    write_node_count('0);
    send(CMD_INIT, node_t'(5), '0);
    send(CMD_QUERY, node_t'(5), '0);

    for (int p = 0; p < 12; p++) begin
      write_node_count(count_t'(counts[p]));
      eff = (counts[p] == 0) ? 1 : (counts[p] > MaxNodes ? MaxNodes : counts[p]);
      idling = !(p == 4 || p == 5);
      random_phase(eff, 110);
    end
    drain();
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/imh_pkg.sv
sv/imh_req_if.sv
sv/imh_res_if.sv
sv/indexed_min_heap_decrease_key.sv
tb/tb.sv
